>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TDV_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Checked on every rising edge, reset included.
`define TDV_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/tdv_pkg.sv
package tdv_pkg;

  // Width of the internal name counter; it saturates at its maximum.
  localparam int NAME_COUNT_WIDTH = 12;
  localparam int LEN_WIDTH = 12;
  localparam int LEN_EXT_WIDTH = (NAME_COUNT_WIDTH > LEN_WIDTH) ? NAME_COUNT_WIDTH : LEN_WIDTH;
  localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

  // Marker characters of a record.
  localparam logic [7:0] MARK_Y = 8'h59;
  localparam logic [7:0] MARK_N = 8'h4E;
  localparam logic [7:0] MARK_D = 8'h44;
  localparam logic [7:0] MARK_R = 8'h52;
  localparam logic [7:0] MARK_T = 8'h54;
  localparam logic [7:0] MARK_X = 8'h58;

  typedef enum logic [2:0] {
    KIND_Y = 3'd0,
    KIND_N = 3'd1,
    KIND_D = 3'd2,
    KIND_R = 3'd3,
    KIND_T = 3'd4,
    KIND_X = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ERR_OK        = 4'd0,
    ERR_TERM      = 4'd1,
    ERR_SEQUENCE  = 4'd2,
    ERR_MARKER    = 4'd3,
    ERR_EMPTY     = 4'd4,
    ERR_RENAME    = 4'd5,
    ERR_TARGET    = 4'd6,
    ERR_TEMPDIR   = 4'd7,
    ERR_NO_TARGET = 4'd8
  } err_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_NAME  = 2'd1,
    PH_OVER  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic                 name_byte_valid;
    logic [7:0]           name_byte;
    logic                 record_done;
    logic [2:0]           record_kind;
    logic [LEN_WIDTH-1:0] name_length;
    logic                 finished;
    logic [3:0]           error_code;
  } result_t;

  typedef struct packed {
    logic  known;
    kind_t kind;
  } marker_t;

  function automatic marker_t decode_marker(input logic [7:0] b);
    marker_t m;
    m.known = 1'b1;
    m.kind  = KIND_Y;
    unique case (b)
      MARK_Y:  m.kind = KIND_Y;
      MARK_N:  m.kind = KIND_N;
      MARK_D:  m.kind = KIND_D;
      MARK_R:  m.kind = KIND_R;
      MARK_T:  m.kind = KIND_T;
      MARK_X:  m.kind = KIND_X;
      default: m.known = 1'b0;
    endcase
    return m;
  endfunction

  function automatic logic [LEN_WIDTH-1:0] sat_length(
    input logic [NAME_COUNT_WIDTH-1:0] cnt
  );
    logic [LEN_EXT_WIDTH-1:0] ext;
    ext = LEN_EXT_WIDTH'(cnt);
    if (ext > LEN_EXT_WIDTH'(LEN_MAX)) begin
      return LEN_MAX;
    end
    return ext[LEN_WIDTH-1:0];
  endfunction

endpackage

>>> hw/rtl/tar_dumpdir_validator.sv
// Streaming checker for an incremental-archive directory listing.
//
// Input channel item_valid/item_ready/item carries one byte of the listing
// per beat, with last_byte marking the final byte of the listing. Output
// channel result_valid/result_ready/result carries exactly one result beat
// for each input beat: a passed-through name byte, a completed record with
// its kind and saturated name length, and on the last byte the final verdict.
//
// The result of a byte is written into the output register on the same edge
// that takes the byte. One byte is taken per cycle while the receiver keeps
// up; the whole per-byte update is a small state machine step between the
// input handshake and the output register.
//
// The block takes a new byte while the previous result is being taken in the
// same cycle, so a receiver that is always ready sees no bubbles. When the
// receiver stalls, the result holds and item_ready drops until it is taken.
//
// Reset (rst, synchronous, active high) empties the output register and puts
// the parser at the start of a fresh listing. After the last byte the parser
// returns to that same state by itself, so listings can follow back to back.
`include "assert_macros.svh"

module tar_dumpdir_validator (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  tdv_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_ready,
  output tdv_pkg::result_t result
);

  localparam int CW = tdv_pkg::NAME_COUNT_WIDTH;

  // Parser state.
  tdv_pkg::phase_t phase, phase_next;
  logic            expect_target, expect_target_next;
  logic            temp_available, temp_available_next;
  tdv_pkg::kind_t  current_kind, current_kind_next;
  logic [CW-1:0]   name_count, name_count_next;
  tdv_pkg::err_t   latched_error, latched_error_next;
  logic            previous_was_zero, previous_was_zero_next;
  logic            first_byte_seen, first_byte_seen_next;

  tdv_pkg::result_t result_next;

  logic             accept;
  logic             byte_zero;
  tdv_pkg::marker_t marker;
  tdv_pkg::err_t    close_err;
  logic             name_empty;

  // A new byte can enter whenever the output register is empty or is being
  // drained in this same cycle.
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  assign byte_zero  = (item.data_byte == 8'd0);
  assign marker     = tdv_pkg::decode_marker(item.data_byte);
  assign name_empty = (name_count == '0);

  // Verdict of the record that a NUL would close now.
  always_comb begin
    close_err = tdv_pkg::ERR_OK;
    unique case (current_kind)
      tdv_pkg::KIND_Y, tdv_pkg::KIND_N, tdv_pkg::KIND_D: begin
        if (name_empty) close_err = tdv_pkg::ERR_EMPTY;
      end
      tdv_pkg::KIND_R: begin
        if (name_empty && !temp_available) close_err = tdv_pkg::ERR_RENAME;
      end
      tdv_pkg::KIND_T: begin
        if (name_empty && !temp_available) close_err = tdv_pkg::ERR_TARGET;
      end
      default: begin
        if (name_empty || temp_available) close_err = tdv_pkg::ERR_TEMPDIR;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    phase_next             = phase;
    expect_target_next     = expect_target;
    temp_available_next    = temp_available;
    current_kind_next      = current_kind;
    name_count_next        = name_count;
    latched_error_next     = latched_error;
    previous_was_zero_next = byte_zero;
    first_byte_seen_next   = 1'b1;

    unique case (phase)
      tdv_pkg::PH_START: begin
        if (byte_zero) begin
          // The empty record ends the listing.
          phase_next = tdv_pkg::PH_OVER;
        end else if (expect_target && (item.data_byte != tdv_pkg::MARK_T)) begin
          latched_error_next = tdv_pkg::ERR_SEQUENCE;
          phase_next         = tdv_pkg::PH_OVER;
        end else if (!marker.known) begin
          latched_error_next = tdv_pkg::ERR_MARKER;
          phase_next         = tdv_pkg::PH_OVER;
        end else begin
          current_kind_next = marker.kind;
          name_count_next   = '0;
          phase_next        = tdv_pkg::PH_NAME;
        end
      end
      tdv_pkg::PH_NAME: begin
        if (!byte_zero) begin
          if (name_count != '1) name_count_next = name_count + CW'(1);
        end else if (close_err != tdv_pkg::ERR_OK) begin
          latched_error_next = close_err;
          phase_next         = tdv_pkg::PH_OVER;
        end else begin
          phase_next = tdv_pkg::PH_START;
          unique case (current_kind)
            tdv_pkg::KIND_R: begin
              if (name_empty) temp_available_next = 1'b0;
              expect_target_next = 1'b1;
            end
            tdv_pkg::KIND_X: begin
              temp_available_next = 1'b1;
              expect_target_next  = 1'b0;
            end
            default: expect_target_next = 1'b0;
          endcase
        end
      end
      default: ;
    endcase

    // The last byte closes the listing; everything returns to its reset value.
    if (item.last_byte) begin
      phase_next             = tdv_pkg::PH_START;
      expect_target_next     = 1'b0;
      temp_available_next    = 1'b0;
      current_kind_next      = tdv_pkg::KIND_Y;
      name_count_next        = '0;
      latched_error_next     = tdv_pkg::ERR_OK;
      previous_was_zero_next = 1'b0;
      first_byte_seen_next   = 1'b0;
    end
  end

  // Result of the byte being taken.
  always_comb begin
    result_next = '0;

    if (phase == tdv_pkg::PH_NAME) begin
      if (!byte_zero) begin
        result_next.name_byte_valid = 1'b1;
        result_next.name_byte       = item.data_byte;
      end else if (close_err == tdv_pkg::ERR_OK) begin
        result_next.record_done = 1'b1;
        result_next.record_kind = current_kind;
        result_next.name_length = tdv_pkg::sat_length(name_count);
      end
    end

    // Before the verdict, the error code shows the record error latched so
    // far, including one found on this very byte.
    result_next.error_code = latched_error;
    if (phase == tdv_pkg::PH_START || phase == tdv_pkg::PH_NAME) begin
      result_next.error_code = (latched_error != tdv_pkg::ERR_OK) ? latched_error :
                               (phase == tdv_pkg::PH_START && !byte_zero &&
                                expect_target && item.data_byte != tdv_pkg::MARK_T) ?
                                 tdv_pkg::ERR_SEQUENCE :
                               (phase == tdv_pkg::PH_START && !byte_zero &&
                                !marker.known) ? tdv_pkg::ERR_MARKER :
                               (phase == tdv_pkg::PH_NAME && byte_zero) ? close_err :
                                 tdv_pkg::ERR_OK;
    end

    if (item.last_byte) begin
      result_next.finished = 1'b1;
      // A listing must end in two NUL bytes or be a single NUL byte; that
      // check wins over every record error.
      if (!byte_zero || (first_byte_seen && !previous_was_zero)) begin
        result_next.error_code = tdv_pkg::ERR_TERM;
      end else if (result_next.error_code != tdv_pkg::ERR_OK) begin
        result_next.error_code = result_next.error_code;
      end else if ((phase == tdv_pkg::PH_NAME && byte_zero &&
                    current_kind == tdv_pkg::KIND_R && close_err == tdv_pkg::ERR_OK) ||
                   ((phase != tdv_pkg::PH_NAME || !byte_zero) && expect_target)) begin
        // A rename whose target never came.
        result_next.error_code = tdv_pkg::ERR_NO_TARGET;
      end else begin
        result_next.error_code = tdv_pkg::ERR_OK;
      end
    end
  end

  // Parser state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= tdv_pkg::PH_START;
      expect_target     <= 1'b0;
      temp_available    <= 1'b0;
      current_kind      <= tdv_pkg::KIND_Y;
      name_count        <= '0;
      latched_error     <= tdv_pkg::ERR_OK;
      previous_was_zero <= 1'b0;
      first_byte_seen   <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      expect_target     <= expect_target_next;
      temp_available    <= temp_available_next;
      current_kind      <= current_kind_next;
      name_count        <= name_count_next;
      latched_error     <= latched_error_next;
      previous_was_zero <= previous_was_zero_next;
      first_byte_seen   <= first_byte_seen_next;
    end
  end

  // Output register; it holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // Every accepted beat leaves a result behind it.
  `TDV_ASSERT(a_beat_yields_result, accept |=> result_valid)
  // The last byte returns the parser to the start of a clean listing.
  `TDV_ASSERT(a_last_clears, (accept && item.last_byte) |=>
    (phase == tdv_pkg::PH_START && latched_error == tdv_pkg::ERR_OK && !expect_target))
  // Once an error is latched, parsing has stopped.
  `TDV_ASSERT(a_error_stops_parse, (latched_error != tdv_pkg::ERR_OK) |-> (phase == tdv_pkg::PH_OVER))
  // A completed record never carries a name byte with it.
  `TDV_ASSERT(a_done_not_name, (result_valid && result.record_done) |-> !result.name_byte_valid)

endmodule
